### rtl/ssh_pkg.sv
// Package for the selectable string hash.
// Holds the algorithm and register codes, hash constants, the item type and the start values.
// No dependencies.
package ssh_pkg;

  // algorithm codes as held in the mode register
  typedef enum logic [2:0] {
    ALG_RS   = 3'd0,
    ALG_JS   = 3'd1,
    ALG_BKDR = 3'd2,
    ALG_SDBM = 3'd3,
    ALG_DJB  = 3'd4,
    ALG_DEK  = 3'd5,
    ALG_BP   = 3'd6,
    ALG_FNV  = 3'd7
  } alg_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_ALGORITHM = 1'b0,
    REG_BKDR_SEED = 1'b1
  } cfg_reg_t;

  localparam int HASH_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [HASH_W-1:0] RS_MUL_STEP  = 32'd378551;
  localparam logic [HASH_W-1:0] RS_MUL_START = 32'd63689;
  localparam logic [HASH_W-1:0] JS_START     = 32'd1315423911;
  localparam logic [HASH_W-1:0] BKDR_DEFAULT = 32'd131;
  localparam logic [HASH_W-1:0] DJB_START    = 32'd5381;
  localparam logic [HASH_W-1:0] FNV_BASIS    = 32'h811C9DC5;
  localparam logic [HASH_W-1:0] FNV_MULT     = 32'h01000193;

  // one string byte with its framing
  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              first_byte;
    logic              last_byte;
    logic [HASH_W-1:0] total_length;
  } item_t;

  // start value of each algorithm; dek starts from the string length
  function automatic logic [HASH_W-1:0] start_value(alg_t alg, logic [HASH_W-1:0] len);
    logic [HASH_W-1:0] v;
    v = '0;
    case (alg)
      ALG_JS:  v = JS_START;
      ALG_DJB: v = DJB_START;
      ALG_DEK: v = len;
      ALG_FNV: v = FNV_BASIS;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/ssh_if.sv
// Valid/ready channel interfaces of the selectable string hash.
// Depends on ssh_pkg for field widths.

// string byte channel
interface ssh_byte_if;
  logic                       valid;
  logic                       ready;
  logic [ssh_pkg::BYTE_W-1:0] byte_value;
  logic                       first_byte;
  logic                       last_byte;
  logic [ssh_pkg::HASH_W-1:0] total_length;

  modport source (output valid, output byte_value, output first_byte,
                  output last_byte, output total_length, input ready);
  modport sink   (input valid, input byte_value, input first_byte,
                  input last_byte, input total_length, output ready);
endinterface

// hash result channel
interface ssh_hash_if;
  logic                       valid;
  logic                       ready;
  logic [ssh_pkg::HASH_W-1:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

### rtl/selectable_string_hash.sv
// Selectable 32-bit string hash, top level.
// Depends on ssh_pkg, ssh_if (ssh_byte_if, ssh_hash_if) and ssh_update.
//
// Usage:
//   byte_in carries one string byte per item with first/last flags and the
//   string length (read on the first byte as the dek start value). hash_out
//   carries one 32-bit hash for each item flagged last.
//   wr_en/wr_index/wr_data write the algorithm (index 0) and bkdr seed
//   (index 1) registers; write them only while no string is in flight.
// Timing:
//   an item is held in the input register, then one hash step runs
//   against the running state; a last byte's hash then loads the result
//   register. One item per cycle is sustained while no last byte waits: the
//   state feedback is one multiply and add through ssh_update.
// Reset:
//   rst (synchronous) empties both registers, selects rs, sets the bkdr
//   seed to 131, the running hash to 0 and the rs multiplier to 63689.
// Stall:
//   while a result waits, non-last bytes keep flowing; a last byte waits
//   in the input register until the result register frees, and byte_in.ready
//   stays low for as long as it waits.
module selectable_string_hash (
  input  logic                          clk,
  input  logic                          rst,
  ssh_byte_if.sink                      byte_in,
  ssh_hash_if.source                    hash_out,
  input  logic                          wr_en,
  input  logic [ssh_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [ssh_pkg::HASH_W-1:0]    wr_data
);

  ssh_pkg::alg_t              algorithm;
  logic [ssh_pkg::HASH_W-1:0] bkdr_seed;
  logic [ssh_pkg::HASH_W-1:0] running_hash;
  logic [ssh_pkg::HASH_W-1:0] rs_mult;
  logic [ssh_pkg::HASH_W-1:0] hash_next;
  logic [ssh_pkg::HASH_W-1:0] rs_mult_next;
  logic                       in_valid;
  ssh_pkg::item_t             in_item;
  logic                       out_valid;
  logic [ssh_pkg::HASH_W-1:0] out_hash;
  logic                       proc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm <= ssh_pkg::ALG_RS;
      bkdr_seed <= ssh_pkg::BKDR_DEFAULT;
    end else if (wr_en) begin
      unique case (ssh_pkg::cfg_reg_t'(wr_index))
        ssh_pkg::REG_ALGORITHM: algorithm <= ssh_pkg::alg_t'(wr_data[2:0]);
        ssh_pkg::REG_BKDR_SEED: bkdr_seed <= wr_data;
        default: ;
      endcase
    end
  end

  // the held item steps unless it is a last byte facing a full result register
  assign proc = in_valid && (!in_item.last_byte || !out_valid || hash_out.ready);
  assign byte_in.ready = !in_valid || proc;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.ready) begin
      in_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.ready && byte_in.valid) begin
      in_item.byte_value   <= byte_in.byte_value;
      in_item.first_byte   <= byte_in.first_byte;
      in_item.last_byte    <= byte_in.last_byte;
      in_item.total_length <= byte_in.total_length;
    end
  end

  // hash step
  ssh_update u_update (
    .alg          (algorithm),
    .seed         (bkdr_seed),
    .hash_cur     (running_hash),
    .rs_mult_cur  (rs_mult),
    .item         (in_item),
    .hash_next    (hash_next),
    .rs_mult_next (rs_mult_next)
  );

  // running state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      rs_mult      <= ssh_pkg::RS_MUL_START;
    end else if (proc) begin
      running_hash <= hash_next;
      rs_mult      <= rs_mult_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && in_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (hash_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_item.last_byte) begin
      out_hash <= hash_next;
    end
  end

  assign hash_out.valid      = out_valid;
  assign hash_out.hash_value = out_hash;

`ifndef NO_ASSERTIONS
  // an empty input register always takes an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> byte_in.ready)
    else $error("byte_in not ready with empty input register");

  // a processed last byte shows its hash next cycle
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (proc && in_item.last_byte) |=> (out_valid && out_hash == $past(hash_next)))
    else $error("last byte did not load the result register");

  // state holds when nothing is processed
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !proc |=> ($stable(running_hash) && $stable(rs_mult)))
    else $error("hash state changed without an item");

  // a first byte outside rs mode restarts the rs multiplier
  a_rs_restart: assert property (@(posedge clk) disable iff (rst)
    (proc && in_item.first_byte && algorithm != ssh_pkg::ALG_RS)
      |=> rs_mult == ssh_pkg::RS_MUL_START)
    else $error("rs multiplier not restarted on first byte");
`endif

endmodule

### rtl/ssh_update.sv
// Per-byte hash update: start value selection and one algorithm step.
// Depends on ssh_pkg for codes, constants and the item type.
module ssh_update (
  input  ssh_pkg::alg_t                alg,
  input  logic [ssh_pkg::HASH_W-1:0]   seed,
  input  logic [ssh_pkg::HASH_W-1:0]   hash_cur,
  input  logic [ssh_pkg::HASH_W-1:0]   rs_mult_cur,
  input  ssh_pkg::item_t               item,
  output logic [ssh_pkg::HASH_W-1:0]   hash_next,
  output logic [ssh_pkg::HASH_W-1:0]   rs_mult_next
);

  logic [ssh_pkg::HASH_W-1:0] h0;
  logic [ssh_pkg::HASH_W-1:0] m0;
  logic [ssh_pkg::HASH_W-1:0] c;
  logic [ssh_pkg::HASH_W-1:0] mul_op;
  logic [ssh_pkg::HASH_W-1:0] prod;

  // first byte loads the start value and restarts the rs multiplier
  assign h0 = item.first_byte ? ssh_pkg::start_value(alg, item.total_length) : hash_cur;
  assign m0 = item.first_byte ? ssh_pkg::RS_MUL_START : rs_mult_cur;

  // byte as a signed char
  assign c = {{(ssh_pkg::HASH_W-ssh_pkg::BYTE_W){item.byte_value[ssh_pkg::BYTE_W-1]}},
              item.byte_value};

  // one shared multiplier for rs, bkdr and fnv, low word kept
  always_comb begin
    unique case (alg)
      ssh_pkg::ALG_RS:   mul_op = m0;
      ssh_pkg::ALG_BKDR: mul_op = seed;
      default:           mul_op = ssh_pkg::FNV_MULT;
    endcase
  end

  assign prod = h0 * mul_op;

  // algorithm step
  always_comb begin
    unique case (alg)
      ssh_pkg::ALG_RS:   hash_next = prod + c;
      ssh_pkg::ALG_JS:   hash_next = h0 ^ ((h0 << 5) + c + (h0 >> 2));
      ssh_pkg::ALG_BKDR: hash_next = prod + c;
      ssh_pkg::ALG_SDBM: hash_next = c + (h0 << 6) + (h0 << 16) - h0;
      ssh_pkg::ALG_DJB:  hash_next = (h0 << 5) + h0 + c;
      ssh_pkg::ALG_DEK:  hash_next = (h0 << 5) ^ (h0 >> 27) ^ c;
      ssh_pkg::ALG_BP:   hash_next = (h0 << 7) ^ c;
      default:           hash_next = prod ^ c;
    endcase
  end

  // rs multiplier only advances on bytes hashed in rs mode
  assign rs_mult_next = (alg == ssh_pkg::ALG_RS) ? m0 * ssh_pkg::RS_MUL_STEP : m0;

endmodule
